>>> design/wre_pkg.sv
// Shared widths, codes and reset values for the windowed rate estimator.
package wre_pkg;

    // Input word fields
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 24;
    localparam int STAMP_W = 32;
    localparam int IN_TDATA_W = CNT_W + STAMP_W;

    // Output word fields
    localparam int RATE_W = 32;
    localparam int TIER_W = 2;
    localparam int OUT_FIELDS_W = RATE_W + TIER_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FILL_W     = 24;
    localparam int LIM_W      = 32;

    // Internal arithmetic
    localparam int SLOT_W = 32;
    localparam int WIN_W  = 40;
    localparam int US_W   = 20;
    localparam int HALF_W = WIN_W / 2;
    localparam int NUM_W  = WIN_W + US_W;
    localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam logic [FILL_W-1:0] FILL_RST = FILL_W'(20000);
    localparam logic [LIM_W-1:0]  LOW_RST  = LIM_W'(10000);
    localparam logic [LIM_W-1:0]  MID_RST  = LIM_W'(100000);

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Tiers
    localparam logic [TIER_W-1:0] TIER_LOW  = 2'd0;
    localparam logic [TIER_W-1:0] TIER_MID  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_HIGH = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID  = 2'd2;

endpackage

>>> design/windowed_rate_estimator_tiers.sv
// Windowed throughput estimator: burst timing, slot history ring, rate and tier.
// Start and add words fold in the idle state and may follow back to back. An end word holds
// the input until its estimate loads: slot read and advance check (plus a recycle step when
// the slot advances), fold, multiply and range check, bit-serial divide and load; a
// saturating quotient skips the divide; a stalled output register adds its wait.
// Reset (i_rst_n low, synchronous) clears state and slot valid bits, loads register defaults.
module windowed_rate_estimator_tiers #(
    parameter int HISTORY_DEPTH = wre_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [wre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wre_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Event stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wre_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // byte_count[23:0], now_us[55:24]
    input  logic [wre_pkg::KIND_W-1:0]        s_axis_tuser,  // kind[1:0]
    // Estimate stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wre_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // rate[31:0], tier[33:32],
                                                             // tier_changed[34], zero[39:35]
);

    import wre_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int DCNT_W = $clog2(RATE_W);
    localparam int RAM_W = 2 * SLOT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,  // take words; start/add fold here
        S_RD0,   // read current slot
        S_RD0W,  // decide slot advance, read next slot
        S_RD1,   // drop recycled slot from window totals
        S_SUMB,  // saturating slot byte sum
        S_SUMT,  // saturating slot time sum, window bytes update
        S_WR,    // window time update, slot write-back
        S_MUL0,  // low partial product
        S_MUL1,  // high partial product and numerator
        S_CHK,   // overflow / zero-time check
        S_DIV,   // one quotient bit per cycle
        S_FIN    // tier pick, load output register
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [FILL_W-1:0] r_fill;
    logic [LIM_W-1:0]  r_low;
    logic [LIM_W-1:0]  r_mid;

    // Estimator state
    logic [SLOT_W-1:0]        r_burst;
    logic [STAMP_W-1:0]       r_stamp;
    logic [PTR_W-1:0]         r_ptr;
    logic [WIN_W-1:0]         r_wb;
    logic [WIN_W-1:0]         r_wt;
    logic [TIER_W-1:0]        r_last_tp1;
    logic [HISTORY_DEPTH-1:0] r_slot_vld;

    // Per-estimate working registers
    logic [STAMP_W-1:0] r_elapsed;
    logic [SLOT_W-1:0]  r_cur_b;
    logic [SLOT_W-1:0]  r_cur_t;
    logic [SLOT_W-1:0]  r_nb;
    logic [SLOT_W-1:0]  r_nt;
    logic [WIN_W-1:0]   r_prod;
    logic [NUM_W-1:0]   r_num;
    logic [WIN_W:0]     r_rem;
    logic [RATE_W-1:0]  r_quo;
    logic [DCNT_W-1:0]  r_cnt;

    // Output register
    logic              r_m_valid;
    logic [RATE_W-1:0] r_m_rate;
    logic [TIER_W-1:0] r_m_tier;
    logic              r_m_chg;

    // Input fields
    logic [KIND_W-1:0]  in_kind;
    logic [CNT_W-1:0]   in_cnt;
    logic [STAMP_W-1:0] in_now;
    logic               in_acc;

    assign in_kind = s_axis_tuser;
    assign in_cnt  = s_axis_tdata[CNT_W-1:0];
    assign in_now  = s_axis_tdata[CNT_W +: STAMP_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Slot ring: bytes in the low half, time in the high half
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    logic             ram_we;

    assign ptr_inc   = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
    assign ram_raddr = (r_state == S_RD0W) ? ptr_inc : r_ptr;
    assign ram_we    = (r_state == S_WR);

    wre_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata ({r_nt, r_nb}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A slot never written since reset reads as zero
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] slot_t;
    assign slot_b = r_slot_vld[r_ptr] ? ram_rdata[SLOT_W-1:0] : '0;
    assign slot_t = r_slot_vld[r_ptr] ? ram_rdata[SLOT_W +: SLOT_W] : '0;

    // Burst accumulate, saturating
    logic [SLOT_W:0] burst_sum;
    assign burst_sum = {1'b0, r_burst} + (SLOT_W + 1)'(in_cnt);

    // Slot advance test
    logic [SLOT_W:0] fill_sum;
    logic            advance;
    assign fill_sum = {1'b0, slot_b} + {1'b0, r_burst};
    assign advance  = (r_burst > SLOT_W'(r_fill)) || (fill_sum > (SLOT_W + 1)'(r_fill));

    // Saturating slot sums
    logic [SLOT_W:0] nb_sum;
    logic [SLOT_W:0] nt_sum;
    assign nb_sum = {1'b0, r_cur_b} + {1'b0, r_burst};
    assign nt_sum = {1'b0, r_cur_t} + {1'b0, r_elapsed};

    // Numerator and divide step
    logic [NUM_W-1:0]     num_hi;
    logic [NUM_W-RATE_W-1:0] num_top;
    logic [WIN_W:0]       trial;
    logic                 ge;
    assign num_hi  = {WIN_W'(r_wb[WIN_W-1:HALF_W]) * WIN_W'(US_PER_S), {HALF_W{1'b0}}};
    assign num_top = r_num[NUM_W-1:RATE_W];
    assign trial   = {r_rem[WIN_W-1:0], r_quo[RATE_W-1]};
    assign ge      = (trial >= {1'b0, r_wt});

    // Tier pick
    logic [TIER_W-1:0] tier;
    always_comb begin
        priority if (r_quo < r_low) begin
            tier = TIER_LOW;
        end else if (r_quo < r_mid) begin
            tier = TIER_MID;
        end else begin
            tier = TIER_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= FILL_RST;
            r_low      <= LOW_RST;
            r_mid      <= MID_RST;
            r_burst    <= '0;
            r_stamp    <= '0;
            r_ptr      <= '0;
            r_wb       <= '0;
            r_wt       <= '0;
            r_last_tp1 <= '0;
            r_slot_vld <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // Register writes land in any state
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FILL: r_fill <= i_cfg_wdata[FILL_W-1:0];
                    CFG_LOW:  r_low  <= i_cfg_wdata[LIM_W-1:0];
                    CFG_MID:  r_mid  <= i_cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end

            // Drop the taken word; the load state refills it itself
            if (r_m_valid && m_axis_tready && r_state != S_FIN) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_kind)
                            KIND_START: begin
                                r_stamp <= in_now;
                                r_burst <= burst_sum[SLOT_W] ? '1 : burst_sum[SLOT_W-1:0];
                            end
                            KIND_ADD: begin
                                r_burst <= burst_sum[SLOT_W] ? '1 : burst_sum[SLOT_W-1:0];
                            end
                            KIND_END: begin
                                r_elapsed <= in_now - r_stamp;
                                r_state   <= S_RD0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD0: begin
                    r_state <= S_RD0W;
                end
                S_RD0W: begin
                    if (advance) begin
                        r_ptr   <= ptr_inc;
                        r_state <= S_RD1;
                    end else begin
                        r_cur_b <= slot_b;
                        r_cur_t <= slot_t;
                        r_state <= S_SUMB;
                    end
                end
                S_RD1: begin
                    // Recycle the slot: drop its old contents from the window
                    r_wb    <= r_wb - WIN_W'(slot_b);
                    r_wt    <= r_wt - WIN_W'(slot_t);
                    r_cur_b <= '0;
                    r_cur_t <= '0;
                    r_state <= S_SUMB;
                end
                S_SUMB: begin
                    r_nb    <= nb_sum[SLOT_W] ? '1 : nb_sum[SLOT_W-1:0];
                    r_state <= S_SUMT;
                end
                S_SUMT: begin
                    r_nt    <= nt_sum[SLOT_W] ? '1 : nt_sum[SLOT_W-1:0];
                    r_wb    <= r_wb + WIN_W'(r_nb - r_cur_b);
                    r_state <= S_WR;
                end
                S_WR: begin
                    // Window time grows only by what the slot really took
                    r_wt              <= r_wt + WIN_W'(r_nt - r_cur_t);
                    r_slot_vld[r_ptr] <= 1'b1;
                    r_burst           <= '0;
                    r_state           <= S_MUL0;
                end
                S_MUL0: begin
                    r_prod  <= WIN_W'(r_wb[HALF_W-1:0]) * WIN_W'(US_PER_S);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_num   <= num_hi + NUM_W'(r_prod);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // Top bits not below the divisor: quotient overflows 32 bits.
                    // Zero window time always lands here too.
                    if (WIN_W'(num_top) >= r_wt) begin
                        r_quo   <= '1;
                        r_state <= S_FIN;
                    end else begin
                        r_rem   <= (WIN_W + 1)'(num_top);
                        r_quo   <= r_num[RATE_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? trial - {1'b0, r_wt} : trial;
                    r_quo <= {r_quo[RATE_W-2:0], ge};
                    r_cnt <= r_cnt + DCNT_W'(1);
                    if (r_cnt == DCNT_W'(RATE_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_rate   <= r_quo;
                        r_m_tier   <= tier;
                        r_m_chg    <= (r_last_tp1 != tier + TIER_W'(1));
                        r_last_tp1 <= tier + TIER_W'(1);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_m_chg, r_m_tier, r_m_rate});

endmodule

>>> design/wre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/wre_chk.sv
// Port-level checker for the windowed rate estimator, bound to the top level.
module wre_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [wre_pkg::KIND_W-1:0]      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wre_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import wre_pkg::*;

    // A stalled estimate word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("estimate word changed while stalled");

    // An end word starts the estimate sequence and blocks the input
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_END |=> !s_axis_tready)
        else $error("input still ready after end word");

    // Words other than end words leave the input ready
    a_fold_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_END |=> s_axis_tready)
        else $error("input not ready after start or add word");

    // Tier is a valid class and the padding stays zero
    a_out_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[RATE_W +: TIER_W] != 2'd3
                          && m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
        else $error("bad tier or nonzero padding in estimate word");

endmodule

bind windowed_rate_estimator_tiers wre_chk u_wre_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/windowed_rate_estimator_tiers_tb.sv
// Self-checking bench for the windowed rate estimator: directed table, random bursts, checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wre_pkg::*;

    localparam int HIST          = HISTORY_DEPTH_DEF;
    localparam int PHASES        = 6;
    localparam int EVENTS_PER_PH = 285;       // random words per phase, ignored kinds not counted
    localparam int FLOOD_ADDS    = 258;       // enough full-size adds to saturate the burst count
    localparam int SETTLE_CYCLES = 64;        // outlasts the whole end-word sequence
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DIR_ROWS      = 23;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [RATE_W-1:0] RATE_SAT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TIER_W-1:0] tier;
        logic              changed;
    } t_estimate;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CNT_W-1:0]   cnt;
        logic [STAMP_W-1:0] stamp;
        bit                 typed;
        logic [RATE_W-1:0]  rate;
        logic [TIER_W-1:0]  tier;
        bit                 changed;
    } t_dir_row;

    // Directed words, default registers. Rows marked typed carry the estimate by hand.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // end straight after reset: no time in the window, first estimate
        '{KIND_END,    24'h00_0000, 32'h0000_0000, 1'b1, RATE_SAT,    TIER_HIGH, 1'b1},
        // unused kind, every field bit high: no effect
        '{KIND_UNUSED, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0,          '0,        1'b0},
        '{KIND_START,  24'h00_0000, 32'd1000,      1'b0, '0,          '0,        1'b0},
        '{KIND_ADD,    24'd1000,    32'h5555_AAAA, 1'b0, '0,          '0,        1'b0},
        // 1000 bytes over 1000 us; the byte field of an end word is ignored
        '{KIND_END,    24'hFF_FFFF, 32'd2000,      1'b1, 32'd1000000, TIER_HIGH, 1'b0},
        '{KIND_START,  24'h00_0000, 32'd5000,      1'b0, '0,          '0,        1'b0},
        // same slot: 1000 bytes over 2000 us
        '{KIND_END,    24'h00_0000, 32'd6000,      1'b1, 32'd500000,  TIER_HIGH, 1'b0},
        '{KIND_START,  24'd10,      32'd0,         1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd1000000,   1'b0, '0,          '0,        1'b0},
        // burst far above the fill limit, elapsed time wraps to one
        '{KIND_START,  24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'h0000_0000, 1'b0, '0,          '0,        1'b0},
        // burst exactly at the limit, slot already full, zero elapsed
        '{KIND_START,  24'd20000,   32'd100,       1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd100,       1'b0, '0,          '0,        1'b0},
        // lots of bytes in one microsecond: quotient overflows
        '{KIND_START,  24'd5000,    32'd0,         1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd1,         1'b0, '0,          '0,        1'b0},
        // maximum elapsed time
        '{KIND_START,  24'd1,       32'd1,         1'b0, '0,          '0,        1'b0},
        '{KIND_ADD,    24'hFF_FFFF, 32'd0,         1'b0, '0,          '0,        1'b0},
        '{KIND_ADD,    24'h00_0000, 32'hAAAA_5555, 1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd0,         1'b0, '0,          '0,        1'b0},
        // two maximum spans into one empty slot: slot time saturates
        '{KIND_START,  24'h00_0000, 32'd1,         1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd0,         1'b0, '0,          '0,        1'b0},
        '{KIND_START,  24'h00_0000, 32'd1,         1'b0, '0,          '0,        1'b0},
        '{KIND_END,    24'h00_0000, 32'd0,         1'b0, '0,          '0,        1'b0}
    };

    // DUT signals; the inputs are known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // byte_count[23:0], now_us[55:24]
    logic [KIND_W-1:0]      s_axis_tuser  = '0;  // kind[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // rate[31:0], tier[33:32], tier_changed[34]

    // Idle rates of the current phase, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned events_sent = 0;

    // Predictor copy of the registers and the estimator state
    logic [FILL_W-1:0]  fill_limit;
    logic [LIM_W-1:0]   low_limit;
    logic [LIM_W-1:0]   mid_limit;
    logic [SLOT_W-1:0]  burst_acc;
    logic [STAMP_W-1:0] burst_start;
    logic [SLOT_W-1:0]  hist_bytes [HIST];
    logic [SLOT_W-1:0]  hist_us    [HIST];
    int unsigned        hist_ptr;
    logic [WIN_W-1:0]   win_bytes;
    logic [WIN_W-1:0]   win_us;
    logic [1:0]         prev_tier_p1;   // zero until the first estimate

    t_estimate expected_estimates [$];

    windowed_rate_estimator_tiers #(
        .HISTORY_DEPTH (HIST)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop if the estimator hangs or an estimate never shows up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t ns: cycle limit reached, %0d estimates outstanding",
                     $time, expected_estimates.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [SLOT_W-1:0] sat_add(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SLOT_W] ? RATE_SAT : sum[SLOT_W-1:0];
    endfunction

    function automatic void clear_estimator();
        fill_limit   = FILL_RST;
        low_limit    = LOW_RST;
        mid_limit    = MID_RST;
        burst_acc    = '0;
        burst_start  = '0;
        hist_ptr     = 0;
        win_bytes    = '0;
        win_us       = '0;
        prev_tier_p1 = '0;
        for (int i = 0; i < HIST; i++) begin
            hist_bytes[i] = '0;
            hist_us[i]    = '0;
        end
    endfunction

    // End word: fold the burst into the slot ring, then divide the window totals.
    function automatic t_estimate fold_burst(logic [STAMP_W-1:0] now);
        logic [STAMP_W-1:0] elapsed;
        logic [SLOT_W-1:0]  grown;
        logic [63:0]        quotient;
        int unsigned        p;
        t_estimate          est;
        elapsed = now - burst_start;
        p       = hist_ptr;
        if ({1'b0, burst_acc} > {9'd0, fill_limit} ||
            {1'b0, hist_bytes[p]} + {1'b0, burst_acc} > {9'd0, fill_limit}) begin
            // move on to the next slot and drop its old share of the window
            p = (p + 1 == HIST) ? 0 : p + 1;
            win_bytes   = win_bytes - WIN_W'(hist_bytes[p]);
            win_us      = win_us - WIN_W'(hist_us[p]);
            hist_bytes[p] = '0;
            hist_us[p]    = '0;
        end
        hist_ptr = p;

        grown         = sat_add(hist_bytes[p], burst_acc);
        win_bytes     = win_bytes + WIN_W'(grown - hist_bytes[p]);
        hist_bytes[p] = grown;
        grown         = sat_add(hist_us[p], elapsed);
        win_us        = win_us + WIN_W'(grown - hist_us[p]);
        hist_us[p]    = grown;
        burst_acc     = '0;

        if (win_us == '0) begin
            est.rate = RATE_SAT;
        end else begin
            quotient = (64'(win_bytes) * 64'd1000000) / 64'(win_us);
            est.rate = (quotient > 64'(RATE_SAT)) ? RATE_SAT : quotient[RATE_W-1:0];
        end
        if (est.rate < low_limit) begin
            est.tier = TIER_LOW;
        end else if (est.rate < mid_limit) begin
            est.tier = TIER_MID;
        end else begin
            est.tier = TIER_HIGH;
        end
        est.changed  = (prev_tier_p1 != est.tier + 2'd1);
        prev_tier_p1 = est.tier + 2'd1;
        return est;
    endfunction

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Receiver: stall at the phase's rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted estimate with the oldest one predicted
    always @(posedge i_clk) begin : estimate_check
        t_estimate want;
        t_estimate got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rate    = m_axis_tdata[31:0];
            got.tier    = m_axis_tdata[33:32];
            got.changed = m_axis_tdata[34];
            if (expected_estimates.size() == 0) begin
                flag_mismatch("unexpected estimate (none pending), rate", '0, got.rate);
            end else begin
                want = expected_estimates.pop_front();
                if (got.rate !== want.rate)
                    flag_mismatch("rate_estimate", want.rate, got.rate);
                if (got.tier !== want.tier)
                    flag_mismatch("tier", 32'(want.tier), 32'(got.tier));
                if (got.changed !== want.changed)
                    flag_mismatch("tier_changed", 32'(want.changed), 32'(got.changed));
            end
        end
    end

    // Send one word: random idle gap first, hold until accepted, then advance the predictor.
    // Leaves tvalid high so the next word can follow back to back.
    task automatic push_event(logic [KIND_W-1:0] kind, logic [CNT_W-1:0] cnt,
                              logic [STAMP_W-1:0] stamp, bit typed, t_estimate typed_est);
        t_estimate est;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {stamp, cnt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        case (kind)
            KIND_START: begin
                burst_start = stamp;
                burst_acc   = sat_add(burst_acc, SLOT_W'(cnt));
            end
            KIND_ADD: begin
                burst_acc = sat_add(burst_acc, SLOT_W'(cnt));
            end
            KIND_END: begin
                est = fold_burst(stamp);
                expected_estimates.push_back(typed ? typed_est : est);
            end
            default: ;
        endcase
        if (kind != KIND_UNUSED) events_sent++;
    endtask

    // Drop valid, wait out every pending estimate, then give the divider time to finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back; only called with the estimator idle
    task automatic load_registers(logic [FILL_W-1:0] fill, logic [LIM_W-1:0] low,
                                  logic [LIM_W-1:0] mid);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_FILL;
        // upper byte is outside the fill register and must be dropped
        i_cfg_wdata <= {8'($urandom), fill};
        @(posedge i_clk);
        fill_limit = fill;
        i_cfg_idx   <= CFG_LOW;
        i_cfg_wdata <= low;
        @(posedge i_clk);
        low_limit = low;
        i_cfg_idx   <= CFG_MID;
        i_cfg_wdata <= mid;
        @(posedge i_clk);
        mid_limit = mid;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r <= 5) return CNT_W'($urandom_range(2000));
        if (r <= 7) return CNT_W'($urandom_range(40000));
        if (r == 8) return CNT_W'($urandom);
        return '1;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_span();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return STAMP_W'($urandom_range(1, 20));
        if (r <= 6) return STAMP_W'($urandom_range(1000, 200000));
        if (r <= 8) return STAMP_W'($urandom_range(5_000_000));
        return STAMP_W'($urandom);
    endfunction

    initial begin : stimulus
        logic [STAMP_W-1:0] run_us;
        logic [STAMP_W-1:0] t0;
        int unsigned        nadd;
        int unsigned        sel;
        int unsigned        seq_no;
        t_estimate          typed_est;

        clear_estimator();
        run_us = STAMP_W'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            // Registers change only with the estimator idle
            if (ph > 0) begin
                drain();
                case (ph)
                    1: load_registers('0, '0, '0);
                    2: load_registers('1, '1, '1);
                    3: begin
                        t0 = STAMP_W'($urandom_range(200000));
                        load_registers(FILL_W'($urandom_range(1000, 50000)), t0,
                                       t0 + STAMP_W'($urandom_range(500000)));
                    end
                    4: load_registers(FILL_RST, 32'd500000, 32'd5000);  // limits inverted
                    default: load_registers(FILL_W'($urandom), LIM_W'($urandom),
                                            LIM_W'($urandom));
                endcase
            end

            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase

            if (ph == 0) begin
                for (int i = 0; i < DIR_ROWS; i++) begin
                    typed_est.rate    = dir_rows[i].rate;
                    typed_est.tier    = dir_rows[i].tier;
                    typed_est.changed = dir_rows[i].changed;
                    push_event(dir_rows[i].kind, dir_rows[i].cnt, dir_rows[i].stamp,
                               dir_rows[i].typed, typed_est);
                end
            end

            events_sent = 0;
            seq_no      = 0;
            while (events_sent < EVENTS_PER_PH) begin
                sel = $urandom_range(99);
                if (seq_no == 0 && (ph == 0 || ph == 2)) begin
                    // flood: burst count runs into saturation
                    push_event(KIND_START, '1, run_us, 1'b0, '0);
                    repeat (FLOOD_ADDS) push_event(KIND_ADD, '1, STAMP_W'($urandom), 1'b0, '0);
                    push_event(KIND_END, pick_count(), run_us + pick_span(), 1'b0, '0);
                end else if (sel < 85) begin
                    // well-formed burst: start, a few adds, end
                    if ($urandom_range(7) == 0) begin
                        run_us = STAMP_W'($urandom);
                    end else begin
                        run_us = run_us + STAMP_W'($urandom_range(100000));
                    end
                    t0 = run_us;
                    push_event(KIND_START, pick_count(), t0, 1'b0, '0);
                    nadd = $urandom_range(4);
                    repeat (nadd) push_event(KIND_ADD, pick_count(), STAMP_W'($urandom), 1'b0, '0);
                    run_us = t0 + pick_span();
                    push_event(KIND_END, CNT_W'($urandom), run_us, 1'b0, '0);
                end else begin
                    // noise and broken bursts
                    case (sel % 5)
                        0: push_event(KIND_END, CNT_W'($urandom), STAMP_W'($urandom), 1'b0, '0);
                        1: push_event(KIND_ADD, pick_count(), STAMP_W'($urandom), 1'b0, '0);
                        2: push_event(KIND_UNUSED, CNT_W'($urandom), STAMP_W'($urandom),
                                      1'b0, '0);
                        3: push_event(KIND_START, pick_count(), STAMP_W'($urandom), 1'b0, '0);
                        default: begin
                            push_event(KIND_END, pick_count(), run_us, 1'b0, '0);
                            push_event(KIND_END, pick_count(), run_us + pick_span(), 1'b0, '0);
                        end
                    endcase
                end
                seq_no++;
            end
        end

        drain();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
